FILE: rtl/cmfuv_pkg.sv
// cmfuv_pkg: shared types and constants of the cube map face / uv pipeline
// used by every module under cube_map_face_uv; no dependencies
package cmfuv_pkg;

  localparam int CoordBits = 16;               // texture coordinate width, unsigned Q0.16
  localparam int DirBits   = 16;               // direction component width
  localparam int MagBits   = DirBits;          // magnitude, holds 2^(DirBits-1)
  localparam int HalfBits  = 14;               // half-tile register width
  localparam int QuoBits   = HalfBits;         // offset never exceeds the half-tile size
  localparam int ProdBits  = MagBits + HalfBits; // numerator 2*m*half + major
  localparam int SumBits   = CoordBits + 2;    // signed centre +/- offset
  localparam int CfgIdxBits = 1;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegHalfW = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegHalfH = 1'b1;

  localparam logic [HalfBits-1:0] HalfWReset = HalfBits'(8191);
  localparam logic [HalfBits-1:0] HalfHReset = HalfBits'(10922);

  // face centres k/d, rounded to nearest with halves up
  localparam int CtrU1 = ((1 << (CoordBits + 1)) + 8) / 16;
  localparam int CtrU3 = ((3 << (CoordBits + 1)) + 8) / 16;
  localparam int CtrU5 = ((5 << (CoordBits + 1)) + 8) / 16;
  localparam int CtrU7 = ((7 << (CoordBits + 1)) + 8) / 16;
  localparam int CtrV1 = ((1 << (CoordBits + 1)) + 6) / 12;
  localparam int CtrV3 = ((3 << (CoordBits + 1)) + 6) / 12;
  localparam int CtrV5 = ((5 << (CoordBits + 1)) + 6) / 12;

  typedef enum logic [2:0] {
    FaceFront  = 3'd0,
    FaceBack   = 3'd1,
    FaceRight  = 3'd2,
    FaceLeft   = 3'd3,
    FaceTop    = 3'd4,
    FaceBottom = 3'd5
  } face_e;

  typedef struct packed {
    face_e face;
    logic  degen;
    logic  neg_u;
    logic  neg_v;
  } side_t;

  // after face selection
  typedef struct packed {
    side_t               side;
    logic [MagBits-1:0]  major;
    logic [MagBits-1:0]  mag_u;
    logic [MagBits-1:0]  mag_v;
  } sel_t;

  // one divider stage
  typedef struct packed {
    side_t               side;
    logic [MagBits-1:0]  major;
    logic [ProdBits-1:0] rem_u;
    logic [ProdBits-1:0] rem_v;
    logic [QuoBits-1:0]  quo_u;
    logic [QuoBits-1:0]  quo_v;
  } div_t;

  // divider result
  typedef struct packed {
    side_t              side;
    logic [QuoBits-1:0] quo_u;
    logic [QuoBits-1:0] quo_v;
  } quo_t;

endpackage

FILE: rtl/cube_map_face_uv.sv
// cube_map_face_uv: maps a direction vector to a cube face and uv coordinates
// of a 4x3 cross texture layout; depends on cmfuv_pkg and the cmfuv_* stages
//
// usage:
//   input stream s_axis_*: one direction item per transfer, x, y, z as
//   16-bit two's complement. output stream m_axis_*: face, tex_u, tex_v in
//   tdata and the zero-vector flag in tuser.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the half-tile width (index 0) and
//   height (index 1); write them only while no item is in flight.
// pipeline: registered stages select, multiply, 14 divider stages of one
//   quotient bit each, map and saturate.
// throughput: one item per cycle while the output is taken; the divider is fully pipelined.
// reset: all stage valid bits clear, the half-tile registers take their reset values.
// stall: when the output item is not taken, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost or repeated.
module cube_map_face_uv
  import cmfuv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [HalfBits-1:0]   cfg_data_i,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // dir_x[15:0], dir_y[31:16], dir_z[47:32]

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // face[2:0], tex_u[18:3], tex_v[34:19], zero pad
  output logic [0:0]            m_axis_tuser   // degenerate[0]
);

  logic [HalfBits-1:0]  half_w_q, half_h_q;
  logic                 en;
  logic                 sel_vld, mul_vld, div_vld;
  sel_t                 sel;
  div_t                 div;
  quo_t                 quo;
  face_e                face;
  logic [CoordBits-1:0] tex_u, tex_v;
  logic                 degen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= HalfWReset;
      half_h_q <= HalfHReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHalfW: half_w_q <= cfg_data_i;
        RegHalfH: half_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output item is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cmfuv_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .dir_x_i (s_axis_tdata[15:0]),
    .dir_y_i (s_axis_tdata[31:16]),
    .dir_z_i (s_axis_tdata[47:32]),
    .valid_o (sel_vld),
    .sel_o   (sel)
  );

  cmfuv_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .half_w_i (half_w_q),
    .half_h_i (half_h_q),
    .valid_i  (sel_vld),
    .sel_i    (sel),
    .valid_o  (mul_vld),
    .div_o    (div)
  );

  cmfuv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mul_vld),
    .div_i   (div),
    .valid_o (div_vld),
    .quo_o   (quo)
  );

  cmfuv_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .quo_i   (quo),
    .valid_o (m_axis_tvalid),
    .face_o  (face),
    .tex_u_o (tex_u),
    .tex_v_o (tex_v),
    .degen_o (degen)
  );

  assign m_axis_tdata = {5'b0, tex_v, tex_u, face};
  assign m_axis_tuser = degen;

endmodule

FILE: rtl/cmfuv_sel.sv
// cmfuv_sel: first stage, picks the major axis, face and minor magnitudes
// depends on cmfuv_pkg
module cmfuv_sel
  import cmfuv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DirBits-1:0] dir_x_i,
  input  logic [DirBits-1:0] dir_y_i,
  input  logic [DirBits-1:0] dir_z_i,
  output logic               valid_o,
  output sel_t               sel_o
);

  logic [MagBits-1:0] ax, ay, az;
  logic               x_pos, y_pos, z_pos;
  sel_t               sel_d, sel_q;
  logic               valid_q;

  always_comb begin
    ax = dir_x_i[DirBits-1] ? MagBits'(~dir_x_i + 1'b1) : MagBits'(dir_x_i);
    ay = dir_y_i[DirBits-1] ? MagBits'(~dir_y_i + 1'b1) : MagBits'(dir_y_i);
    az = dir_z_i[DirBits-1] ? MagBits'(~dir_z_i + 1'b1) : MagBits'(dir_z_i);
    x_pos = !dir_x_i[DirBits-1] && (dir_x_i != '0);
    y_pos = !dir_y_i[DirBits-1] && (dir_y_i != '0);
    z_pos = !dir_z_i[DirBits-1] && (dir_z_i != '0);

    sel_d.side.degen = (ax == '0) && (ay == '0) && (az == '0);
    // ties go to z, then x
    if (az >= ax && az >= ay) begin
      sel_d.side.face  = z_pos ? FaceFront : FaceBack;
      sel_d.major      = az;
      sel_d.mag_u      = ax;
      sel_d.side.neg_u = dir_x_i[DirBits-1];
      sel_d.mag_v      = ay;
      sel_d.side.neg_v = dir_y_i[DirBits-1];
    end else if (ax >= ay) begin
      sel_d.side.face  = x_pos ? FaceRight : FaceLeft;
      sel_d.major      = ax;
      sel_d.mag_u      = az;
      sel_d.side.neg_u = dir_z_i[DirBits-1];
      sel_d.mag_v      = ay;
      sel_d.side.neg_v = dir_y_i[DirBits-1];
    end else begin
      sel_d.side.face  = y_pos ? FaceTop : FaceBottom;
      sel_d.major      = ay;
      sel_d.mag_u      = ax;
      sel_d.side.neg_u = dir_x_i[DirBits-1];
      sel_d.mag_v      = az;
      sel_d.side.neg_v = dir_z_i[DirBits-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= sel_d;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

FILE: rtl/cmfuv_mul.sv
// cmfuv_mul: scales both minor magnitudes by the half-tile sizes and forms
// the rounded division numerators; depends on cmfuv_pkg
module cmfuv_mul
  import cmfuv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [HalfBits-1:0] half_w_i,
  input  logic [HalfBits-1:0] half_h_i,
  input  logic                valid_i,
  input  sel_t                sel_i,
  output logic                valid_o,
  output div_t                div_o
);

  logic [ProdBits-1:0] prod_u, prod_v;
  div_t                div_d, div_q;
  logic                valid_q;

  always_comb begin
    prod_u = ProdBits'(sel_i.mag_u) * ProdBits'(half_w_i);
    prod_v = ProdBits'(sel_i.mag_v) * ProdBits'(half_h_i);
    div_d.side  = sel_i.side;
    div_d.major = sel_i.major;
    // 2*p + major, divided later by 2*major gives round half away
    div_d.rem_u = {prod_u[ProdBits-2:0], 1'b0} + ProdBits'(sel_i.major);
    div_d.rem_v = {prod_v[ProdBits-2:0], 1'b0} + ProdBits'(sel_i.major);
    div_d.quo_u = '0;
    div_d.quo_v = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

FILE: rtl/cmfuv_div.sv
// cmfuv_div: pipelined restoring divider, one quotient bit per stage for
// both lanes at once; depends on cmfuv_pkg
module cmfuv_div
  import cmfuv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output quo_t quo_o
);

  localparam int WideBits = ProdBits + 1;

  div_t               stg_q [QuoBits];
  logic [QuoBits-1:0] vld_q;

  for (genvar k = 0; k < QuoBits; k++) begin : g_step
    localparam int Sh = QuoBits - 1 - k;

    logic [WideBits-1:0] trial, diff_u, diff_v;
    div_t                stg_in, stg_d;
    logic                vld_in;

    if (k == 0) begin : g_first
      assign stg_in = div_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign stg_in = stg_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    always_comb begin
      trial  = WideBits'({stg_in.major, 1'b0}) << Sh;
      diff_u = {1'b0, stg_in.rem_u} - trial;
      diff_v = {1'b0, stg_in.rem_v} - trial;
      stg_d  = stg_in;
      if (!diff_u[WideBits-1]) begin
        stg_d.rem_u     = diff_u[ProdBits-1:0];
        stg_d.quo_u[Sh] = 1'b1;
      end
      if (!diff_v[WideBits-1]) begin
        stg_d.rem_v     = diff_v[ProdBits-1:0];
        stg_d.quo_v[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d;
      end
    end
  end

  assign valid_o     = vld_q[QuoBits-1];
  assign quo_o.side  = stg_q[QuoBits-1].side;
  assign quo_o.quo_u = stg_q[QuoBits-1].quo_u;
  assign quo_o.quo_v = stg_q[QuoBits-1].quo_v;

endmodule

FILE: rtl/cmfuv_map.sv
// cmfuv_map: adds the signed offsets to the face centres of the cross layout,
// saturates and holds the output item; depends on cmfuv_pkg
module cmfuv_map
  import cmfuv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  quo_t                 quo_i,
  output logic                 valid_o,
  output face_e                face_o,
  output logic [CoordBits-1:0] tex_u_o,
  output logic [CoordBits-1:0] tex_v_o,
  output logic                 degen_o
);

  localparam logic signed [SumBits-1:0] CoordMax = SumBits'((1 << CoordBits) - 1);

  logic signed [SumBits-1:0] cu, cv, off_u, off_v, sum_u, sum_v;
  logic                      sub_u, sub_v;
  logic [CoordBits-1:0]      tex_u_d, tex_v_d, tex_u_q, tex_v_q;
  face_e                     face_q;
  logic                      degen_q, valid_q;

  always_comb begin
    sub_u = 1'b0;
    sub_v = 1'b0;
    cu    = SumBits'(CtrU3);
    cv    = SumBits'(CtrV3);
    case (quo_i.side.face)
      FaceFront: ;
      FaceBack: begin
        cu    = SumBits'(CtrU7);
        sub_u = 1'b1;
      end
      FaceRight: begin
        cu    = SumBits'(CtrU5);
        sub_u = 1'b1;
      end
      FaceLeft: begin
        cu    = SumBits'(CtrU1);
      end
      FaceTop: begin
        cv    = SumBits'(CtrV5);
        sub_v = 1'b1;
      end
      FaceBottom: begin
        cv    = SumBits'(CtrV1);
      end
      default: ;
    endcase

    off_u = (sub_u ^ quo_i.side.neg_u) ? -SumBits'(quo_i.quo_u) : SumBits'(quo_i.quo_u);
    off_v = (sub_v ^ quo_i.side.neg_v) ? -SumBits'(quo_i.quo_v) : SumBits'(quo_i.quo_v);
    sum_u = cu + off_u;
    sum_v = cv + off_v;

    if (sum_u < 0) begin
      tex_u_d = '0;
    end else if (sum_u > CoordMax) begin
      tex_u_d = '1;
    end else begin
      tex_u_d = sum_u[CoordBits-1:0];
    end
    if (sum_v < 0) begin
      tex_v_d = '0;
    end else if (sum_v > CoordMax) begin
      tex_v_d = '1;
    end else begin
      tex_v_d = sum_v[CoordBits-1:0];
    end

    // zero vector lands on the back-face centre
    if (quo_i.side.degen) begin
      tex_u_d = CoordBits'(CtrU7);
      tex_v_d = CoordBits'(CtrV3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      face_q  <= quo_i.side.degen ? FaceBack : quo_i.side.face;
      degen_q <= quo_i.side.degen;
      tex_u_q <= tex_u_d;
      tex_v_q <= tex_v_d;
    end
  end

  assign valid_o = valid_q;
  assign face_o  = face_q;
  assign tex_u_o = tex_u_q;
  assign tex_v_o = tex_v_q;
  assign degen_o = degen_q;

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for cube_map_face_uv, face pick and cross-layout uv mapping
// drives direction items with random gaps and output stalls and checks each result
// against an in-bench predictor; depends on cmfuv_pkg and the rtl of cube_map_face_uv
module tb;
  import cmfuv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    face_e       face;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        degen;
  } uv_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = RegHalfW;
  logic [HalfBits-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;   // dir_x, dir_y, dir_z
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;        // face, tex_u, tex_v, zero pad
  logic [0:0]            m_axis_tuser;        // degenerate

  logic [HalfBits-1:0] tile_w = HalfWReset;
  logic [HalfBits-1:0] tile_h = HalfHReset;
  uv_t uv_due [$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  int  sink_wait = 0;

  cube_map_face_uv dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // k/d in Q0.16, halves rounded up
  function automatic longint face_ctr(longint k, longint d);
    return ((k << 17) + d) / (2 * d);
  endfunction

  // minor * half / major on magnitudes, halves away from zero, sign of minor
  function automatic longint tile_offset(longint minor, longint half, longint major);
    longint m, q;
    m = (minor < 0) ? -minor : minor;
    q = (2 * m * half + major) / (2 * major);
    return (minor < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clip16(longint c);
    if (c < 0) return 16'd0;
    if (c > 65535) return 16'hFFFF;
    return 16'(c);
  endfunction

  function automatic uv_t map_dir(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
    longint xi, yi, zi, ax, ay, az, u, v, du, dv, hw, hh;
    uv_t r;
    xi = longint'(x);
    yi = longint'(y);
    zi = longint'(z);
    hw = longint'(tile_w);
    hh = longint'(tile_h);
    ax = (xi < 0) ? -xi : xi;
    ay = (yi < 0) ? -yi : yi;
    az = (zi < 0) ? -zi : zi;
    r.degen = (ax == 0 && ay == 0 && az == 0);
    if (r.degen) begin
      r.face = FaceBack;
      u = face_ctr(7, 8);
      v = face_ctr(3, 6);
    end else if (az >= ax && az >= ay) begin
      du = tile_offset(xi, hw, az);
      dv = tile_offset(yi, hh, az);
      if (zi > 0) begin
        r.face = FaceFront;
        u = face_ctr(3, 8) + du;
      end else begin
        r.face = FaceBack;
        u = face_ctr(7, 8) - du;
      end
      v = face_ctr(3, 6) + dv;
    end else if (ax >= ay) begin
      du = tile_offset(zi, hw, ax);
      dv = tile_offset(yi, hh, ax);
      if (xi > 0) begin
        r.face = FaceRight;
        u = face_ctr(5, 8) - du;
      end else begin
        r.face = FaceLeft;
        u = face_ctr(1, 8) + du;
      end
      v = face_ctr(3, 6) + dv;
    end else begin
      du = tile_offset(xi, hw, ay);
      dv = tile_offset(zi, hh, ay);
      u = face_ctr(3, 8) + du;
      if (yi > 0) begin
        r.face = FaceTop;
        v = face_ctr(5, 6) - dv;
      end else begin
        r.face = FaceBottom;
        v = face_ctr(1, 6) + dv;
      end
    end
    r.tex_u = clip16(u);
    r.tex_v = clip16(v);
    return r;
  endfunction

  // valid stays high on return so back-to-back items need no extra edge
  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    uv_due.push_back(map_dir(x, y, z));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (uv_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_tiles(logic [HalfBits-1:0] w, logic [HalfBits-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegHalfW;
    cfg_data_i <= w;
    @(posedge clk_i);
    tile_w = w;
    cfg_idx_i  <= RegHalfH;
    cfg_data_i <= h;
    @(posedge clk_i);
    tile_h = h;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random();
    logic signed [15:0] c [3];
    logic signed [15:0] edges [6];
    int kind, mag;
    edges = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    kind = $urandom_range(0, 9);
    mag  = $urandom_range(1, 32768);
    for (int i = 0; i < 3; i++) begin
      if (kind <= 4) c[i] = 16'($urandom);
      else if (kind <= 6) begin
        // equal magnitudes on some axes to hit the tie rules
        if ($urandom_range(0, 2) == 0) c[i] = 16'($urandom_range(0, mag) - mag / 2);
        else c[i] = 16'($urandom_range(0, 1) ? -mag : mag);
      end else if (kind == 7) c[i] = 16'(int'($urandom_range(0, 6)) - 3);
      else c[i] = edges[3'($urandom_range(0, 5))];
    end
    send_dir(c[0], c[1], c[2]);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random();
    end
    quiet = 1'b0;
  endtask

  task automatic test_directed();
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sd32767, 16'sd0, 16'sd0);
    send_dir(-16'sd32768, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd32767, 16'sd0);
    send_dir(16'sd0, -16'sd32768, 16'sd0);
    send_dir(16'sd0, 16'sd0, 16'sd32767);
    send_dir(16'sd0, 16'sd0, -16'sd32768);
    send_dir(16'sd1000, 16'sd1000, 16'sd1000);
    send_dir(-16'sd1000, -16'sd1000, -16'sd1000);
    send_dir(16'sd700, -16'sd700, 16'sd0);
    send_dir(-16'sd700, 16'sd700, 16'sd0);
    send_dir(16'sd0, -16'sd5, 16'sd5);
    send_dir(-16'sd32768, 16'sd32767, -16'sd32768);
    send_dir(16'sd32767, -16'sd32768, -16'sd32768);
    send_dir(-16'sd32768, -16'sd32768, 16'sd32767);
    send_dir(16'sd32767, -16'sd32768, 16'sd100);
    send_dir(-16'sd32767, 16'sd32767, -16'sd32768);
    send_dir(16'sd1, 16'sd0, 16'sd0);
    send_dir(16'sd0, 16'sd0, -16'sd1);
    send_dir(-16'sd1, 16'sd1, -16'sd1);
    send_dir(16'sd12345, -16'sd23456, 16'sd30000);
    send_dir(16'sd0, 16'sd32767, -16'sd32767);
    drain();
  endtask

  // reset register values, with a full stop halfway through
  task automatic test_random_mix();
    run_random(40);
    drain();
    run_random(40);
    drain();
  endtask

  task automatic test_tile_sizes();
    logic [HalfBits-1:0] w_set [6];
    logic [HalfBits-1:0] h_set [6];
    w_set = '{14'd0, 14'd8192, 14'h3FFF, 14'd1, 14'($urandom), 14'd8191};
    h_set = '{14'd0, 14'd10923, 14'h3FFF, 14'd1, 14'($urandom), 14'd10922};
    for (int s = 0; s < 6; s++) begin
      set_tiles(w_set[s], h_set[s]);
      send_dir(-16'sd32767, 16'sd32767, -16'sd32768);
      send_dir(16'sd32767, -16'sd32768, -16'sd32768);
      run_random(90);
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    uv_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (uv_due.size() == 0) begin
        $error("result with no item pending: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        exp_r = uv_due.pop_front();
        if (m_axis_tdata[2:0] !== exp_r.face) begin
          $error("face: expected %0d, got %0d", exp_r.face, m_axis_tdata[2:0]);
          mismatches++;
        end
        if (m_axis_tdata[18:3] !== exp_r.tex_u) begin
          $error("tex_u: expected %0d, got %0d", exp_r.tex_u, m_axis_tdata[18:3]);
          mismatches++;
        end
        if (m_axis_tdata[34:19] !== exp_r.tex_v) begin
          $error("tex_v: expected %0d, got %0d", exp_r.tex_v, m_axis_tdata[34:19]);
          mismatches++;
        end
        if (m_axis_tuser[0] !== exp_r.degen) begin
          $error("degenerate: expected %0d, got %0d", exp_r.degen, m_axis_tuser[0]);
          mismatches++;
        end
      end
      sink_wait = pick_gap();
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    m_axis_tready <= (sink_wait == 0);
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix();
    test_tile_sizes();
    drain();
    // room for any stray result after the pipeline empties
    repeat (25) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
